/* sv/tfr_pkg.sv */
// Shared types and constants for the TLV8 fragment reassembler.
// No dependencies; every other file of the block uses this package.
package tfr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);
  localparam logic [LEN_W-1:0] CAPACITY_RESET = 16'hFFFF;
  localparam logic [BYTE_W-1:0] TARGET_RESET  = 8'h00;

  typedef enum logic [0:0] {
    REG_TARGET_TYPE = 1'b0,
    REG_CAPACITY    = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_TYPE  = 2'd0,
    PH_LEN   = 2'd1,
    PH_VALUE = 2'd2
  } phase_t;

  // One classified byte handed from the parser to the counting stage.
  typedef struct packed {
    logic              copy_ok;   // value byte inside the copy run
    logic [BYTE_W-1:0] data;
    logic              elem_end;  // this byte completes an element
    logic              last;      // final byte of the buffer
    logic              perr;      // buffer ended inside an element
  } cmd_t;

  // Status the parser shows the counting stage for capacity writes.
  typedef struct packed {
    logic run_started;
  } front_status_t;

endpackage

/* sv/tfr_if.sv */
// Stream interfaces for the TLV8 fragment reassembler ports.
// Depends on tfr_pkg for field widths.
interface tfr_in_if;
  logic                       valid;
  logic                       ready;
  logic [tfr_pkg::BYTE_W-1:0] data_byte;
  logic                       last_in_buffer;

  modport source (output valid, data_byte, last_in_buffer, input ready);
  modport sink   (input valid, data_byte, last_in_buffer, output ready);
endinterface

interface tfr_out_if;
  logic                       valid;
  logic                       ready;
  logic                       data_valid;
  logic [tfr_pkg::BYTE_W-1:0] out_byte;
  logic                       done_res;
  logic [tfr_pkg::LEN_W-1:0]  copied_length;
  logic                       parse_error;

  modport source (output valid, data_valid, out_byte, done_res, copied_length,
                  parse_error, input ready);
  modport sink   (input valid, data_valid, out_byte, done_res, copied_length,
                  parse_error, output ready);
endinterface

/* sv/tfr_front.sv */
// Parser front end: tracks the TLV8 element phase and the copy run, and
// classifies each accepted byte into a command. Depends on tfr_pkg.
module tfr_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [tfr_pkg::BYTE_W-1:0] in_byte,
  input  logic                       in_last,
  input  logic                       accept,
  input  logic                       target_we,
  input  logic [tfr_pkg::BYTE_W-1:0] target_data,
  output tfr_pkg::cmd_t              cmd,
  output logic                       cmd_push,
  output tfr_pkg::front_status_t     status
);

  tfr_pkg::phase_t            phase, phase_next;
  logic [tfr_pkg::BYTE_W-1:0] target_type;
  logic [tfr_pkg::BYTE_W-1:0] value_bytes_left, value_bytes_left_next;
  logic                       copying, copying_next;
  logic                       stopped, stopped_next;
  logic                       elem_end;
  logic                       type_match;

  assign type_match = (in_byte == target_type);

  always_comb begin
    unique case (phase)
      tfr_pkg::PH_TYPE:  phase_next = tfr_pkg::PH_LEN;
      tfr_pkg::PH_LEN:   phase_next = (in_byte == '0) ? tfr_pkg::PH_TYPE : tfr_pkg::PH_VALUE;
      tfr_pkg::PH_VALUE: phase_next = (value_bytes_left == 8'd1) ? tfr_pkg::PH_TYPE
                                                                  : tfr_pkg::PH_VALUE;
      default:           phase_next = tfr_pkg::PH_TYPE;
    endcase
  end

  always_comb begin
    copying_next          = copying;
    stopped_next          = stopped;
    value_bytes_left_next = value_bytes_left;
    elem_end              = 1'b0;
    unique case (phase)
      tfr_pkg::PH_TYPE: begin
        if (!stopped) begin
          if (!copying) begin
            copying_next = type_match;
          end else if (!type_match) begin
            copying_next = 1'b0;
            stopped_next = 1'b1;
          end
        end
      end
      tfr_pkg::PH_LEN: begin
        value_bytes_left_next = in_byte;
        elem_end              = (in_byte == '0);
      end
      tfr_pkg::PH_VALUE: begin
        value_bytes_left_next = value_bytes_left - 8'd1;
        elem_end              = (value_bytes_left == 8'd1);
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd.copy_ok  = (phase == tfr_pkg::PH_VALUE) && copying && !stopped;
    cmd.data     = in_byte;
    cmd.elem_end = elem_end;
    cmd.last     = in_last;
    cmd.perr     = (phase_next != tfr_pkg::PH_TYPE);
    // Type bytes and opening length bytes change no count; unless last in the buffer, they are dropped here.
    cmd_push     = in_valid && accept && (cmd.copy_ok || elem_end || in_last);
    status.run_started = copying || stopped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= tfr_pkg::PH_TYPE;
      value_bytes_left <= '0;
      copying          <= 1'b0;
      stopped          <= 1'b0;
      target_type      <= tfr_pkg::TARGET_RESET;
    end else begin
      if (target_we) begin
        target_type <= target_data;
      end
      if (in_valid && accept) begin
        if (in_last) begin
          phase            <= tfr_pkg::PH_TYPE;
          value_bytes_left <= '0;
          copying          <= 1'b0;
          stopped          <= 1'b0;
        end else begin
          phase            <= phase_next;
          value_bytes_left <= value_bytes_left_next;
          copying          <= copying_next;
          stopped          <= stopped_next;
        end
      end
    end
  end

endmodule

/* sv/tfr_queue.sv */
// Short command queue between the parser and the counting stage.
// Depends on tfr_pkg for the command type and depth.
module tfr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tfr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output tfr_pkg::cmd_t head_cmd,
  output logic          head_valid
);

  tfr_pkg::cmd_t              entries [tfr_pkg::QDEPTH];
  logic [tfr_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [tfr_pkg::QCNT_W-1:0] count;
  logic                       do_push, do_pop;

  assign full       = (count == tfr_pkg::QCNT_W'(tfr_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/tfr_back.sv */
// Counting back end: applies the capacity limit, keeps the committed length
// and drives the registered result. Depends on tfr_pkg and tfr_out_if.
module tfr_back (
  input  logic                      clk,
  input  logic                      rst,
  input  tfr_pkg::cmd_t             cmd,
  input  logic                      cmd_valid,
  output logic                      cmd_pop,
  input  tfr_pkg::front_status_t    status,
  input  logic                      cap_we,
  input  logic [tfr_pkg::LEN_W-1:0] cap_data,
  tfr_out_if.source                 out_stream
);

  logic [tfr_pkg::LEN_W-1:0] capacity;
  logic [tfr_pkg::LEN_W-1:0] capacity_left;
  logic [tfr_pkg::LEN_W-1:0] committed_length, committed_next;
  logic [tfr_pkg::LEN_W-1:0] element_copied, element_copied_next;
  logic                      pass_byte;
  logic                      has_result;
  logic                      slot_free;

  assign pass_byte           = cmd.copy_ok && (capacity_left != '0);
  assign element_copied_next = element_copied + tfr_pkg::LEN_W'(pass_byte);
  assign committed_next      = cmd.elem_end ? committed_length + element_copied_next
                                            : committed_length;
  assign has_result          = pass_byte || cmd.last;
  assign slot_free           = !out_stream.valid || out_stream.ready;
  // A command without a result retires even while the output slot is full.
  assign cmd_pop             = cmd_valid && (!has_result || slot_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity         <= tfr_pkg::CAPACITY_RESET;
      capacity_left    <= tfr_pkg::CAPACITY_RESET;
      committed_length <= '0;
      element_copied   <= '0;
    end else begin
      if (cmd_pop) begin
        if (cmd.last) begin
          committed_length <= '0;
          element_copied   <= '0;
        end else begin
          committed_length <= committed_next;
          element_copied   <= cmd.elem_end ? '0 : element_copied_next;
        end
      end
      if (cap_we) begin
        capacity <= cap_data;
      end
      if (cap_we && !status.run_started) begin
        capacity_left <= cap_data;
      end else if (cmd_pop && cmd.last) begin
        capacity_left <= capacity;
      end else if (cmd_pop && pass_byte) begin
        capacity_left <= capacity_left - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_stream.valid <= 1'b0;
    end else if (slot_free) begin
      out_stream.valid <= cmd_valid && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && cmd_valid && has_result) begin
      out_stream.data_valid    <= pass_byte;
      out_stream.out_byte      <= pass_byte ? cmd.data : '0;
      out_stream.done_res      <= cmd.last;
      out_stream.copied_length <= cmd.last ? committed_next : '0;
      out_stream.parse_error   <= cmd.last && cmd.perr;
    end
  end

endmodule

/* sv/tlv8_fragment_reassembler.sv */
// Top level of the TLV8 fragment reassembler: parser, command queue and
// counting stage. Depends on tfr_pkg, tfr_if, tfr_front, tfr_queue, tfr_back.
//
// Reassembles the value bytes of consecutive TLV8 elements of type target_type
// from a byte stream, up to capacity bytes per buffer, and reports the length
// copied from complete elements on the buffer's last byte (parse_error set when
// the buffer ends inside an element). The block takes one byte per clock while
// the four-entry command queue has room; results leave via the registered output.
// The counting stage drains one command per clock while the output register is
// free or being taken, and commands with no result even while it is full. Only
// value bytes of the copy run, element ends and buffer ends produce commands.
// Configuration writes go straight to the registers: target_type applies at the
// next type byte, capacity at once if the current buffer has not reached its copy
// run, else next buffer.
module tlv8_fragment_reassembler (
  input  logic                      clk,
  input  logic                      rst,
  tfr_in_if.sink                    in_stream,
  tfr_out_if.source                 out_stream,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [tfr_pkg::CFG_W-1:0] cfg_data
);

  tfr_pkg::cmd_t          push_cmd, head_cmd;
  tfr_pkg::front_status_t status;
  logic                   push, full, pop, head_valid;
  logic                   target_we, cap_we;

  assign target_we       = cfg_we && (cfg_index == tfr_pkg::REG_TARGET_TYPE);
  assign cap_we          = cfg_we && (cfg_index == tfr_pkg::REG_CAPACITY);
  assign in_stream.ready = !full;

  tfr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_stream.valid),
    .in_byte     (in_stream.data_byte),
    .in_last     (in_stream.last_in_buffer),
    .accept      (!full),
    .target_we   (target_we),
    .target_data (cfg_data[tfr_pkg::BYTE_W-1:0]),
    .cmd         (push_cmd),
    .cmd_push    (push),
    .status      (status)
  );

  tfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_cmd   (head_cmd),
    .head_valid (head_valid)
  );

  tfr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (head_cmd),
    .cmd_valid  (head_valid),
    .cmd_pop    (pop),
    .status     (status),
    .cap_we     (cap_we),
    .cap_data   (cfg_data[tfr_pkg::LEN_W-1:0]),
    .out_stream (out_stream)
  );

endmodule

/* tb/tlv8_fragment_reassembler_tb.sv */
// Self-checking testbench for tlv8_fragment_reassembler: a directed table,
// then random TLV8 buffers with random stalls on both streams.
// Depends on tfr_pkg, tfr_if and the block's RTL.
module tlv8_fragment_reassembler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1550;
  localparam int unsigned QUIET_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic                       dv;
    logic [tfr_pkg::BYTE_W-1:0] ob;
    logic                       done;
    logic [tfr_pkg::LEN_W-1:0]  clen;
    logic                       perr;
  } reasm_result_t;

  localparam reasm_result_t NO_RESULT = '0;

  typedef enum bit {ROW_BYTE, ROW_CFG} row_kind_t;

  // Byte rows use v0[7:0] as the byte; settings rows carry target (v0) and capacity (v1).
  typedef struct packed {
    row_kind_t     kind;
    logic [15:0]   v0;
    logic [15:0]   v1;
    logic          last;
    bit            typed;
    reasm_result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [tfr_pkg::CFG_W-1:0] cfg_data;

  tfr_in_if  in_s ();
  tfr_out_if out_s ();

  tlv8_fragment_reassembler u_top (
    .clk        (clk),
    .rst        (rst),
    .in_stream  (in_s),
    .out_stream (out_s),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Expected behavior of the block, kept in step with accepted transfers.
  logic [tfr_pkg::BYTE_W-1:0] reg_target;
  logic [tfr_pkg::LEN_W-1:0]  reg_capacity;
  tfr_pkg::phase_t            st_phase;
  logic [7:0]                 st_left;
  bit                         st_copying;
  bit                         st_stopped;
  logic [tfr_pkg::LEN_W-1:0]  st_cap_left;
  logic [tfr_pkg::LEN_W-1:0]  st_committed;
  logic [tfr_pkg::LEN_W-1:0]  st_elem_copied;

  reasm_result_t     pending_results[$];
  logic [7:0]        buf_bytes[$];
  int unsigned       errors = 0;
  int unsigned       cycles = 0;
  int unsigned       in_mode = 0;
  int unsigned       out_mode = 0;
  int unsigned       out_hold = 0;

  dir_row_t directed_rows[] = '{
    '{ROW_BYTE, 16'h0000, 16'h0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 16'h0002, 16'h0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 16'h00FF, 16'h0, 1'b0, 1'b1, '{1'b1, 8'hFF, 1'b0, 16'd0, 1'b0}},
    '{ROW_BYTE, 16'h0000, 16'h0, 1'b0, 1'b1, '{1'b1, 8'h00, 1'b0, 16'd0, 1'b0}},
    // A zero-length element of the same type keeps the run going.
    '{ROW_BYTE, 16'h0000, 16'h0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 16'h0000, 16'h0, 1'b0, 1'b0, NO_RESULT},
    // Another type ends the run for good.
    '{ROW_BYTE, 16'h0005, 16'h0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 16'h0001, 16'h0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 16'h00AA, 16'h0, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 16'd2, 1'b0}},
    // Buffer ends inside a long element of a foreign type.
    '{ROW_BYTE, 16'h00FF, 16'h0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 16'h00FF, 16'h0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 16'h005A, 16'h0, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 16'd0, 1'b1}},
    // Buffer ends on a type byte, then on a length byte.
    '{ROW_BYTE, 16'h0000, 16'h0, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 16'd0, 1'b1}},
    '{ROW_BYTE, 16'h0000, 16'h0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 16'h0001, 16'h0, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 16'd0, 1'b1}},
    // Truncated matching element: bytes go out but are not counted.
    '{ROW_BYTE, 16'h0000, 16'h0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 16'h0003, 16'h0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 16'h0011, 16'h0, 1'b0, 1'b1, '{1'b1, 8'h11, 1'b0, 16'd0, 1'b0}},
    '{ROW_BYTE, 16'h0022, 16'h0, 1'b1, 1'b1, '{1'b1, 8'h22, 1'b1, 16'd0, 1'b1}},
    // Upper bits of the target write must be ignored; zero capacity passes nothing.
    '{ROW_CFG,  16'hA5FF, 16'h0000, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 16'h00FF, 16'h0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 16'h0001, 16'h0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 16'h0077, 16'h0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 16'h00FF, 16'h0, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BYTE, 16'h0000, 16'h0, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 16'd0, 1'b0}}
  };

  function automatic void clear_buffer_state();
    st_phase       = tfr_pkg::PH_TYPE;
    st_left        = '0;
    st_copying     = 1'b0;
    st_stopped     = 1'b0;
    st_cap_left    = reg_capacity;
    st_committed   = '0;
    st_elem_copied = '0;
  endfunction

  function automatic void close_element();
    st_committed   = st_committed + st_elem_copied;
    st_elem_copied = '0;
    st_phase       = tfr_pkg::PH_TYPE;
  endfunction

  function automatic bit predict_fragment(input logic [7:0] b, input logic last,
                                          output reasm_result_t r);
    r = '0;
    case (st_phase)
      tfr_pkg::PH_TYPE: begin
        if (!st_stopped) begin
          if (!st_copying) begin
            st_copying = (b == reg_target);
          end else if (b != reg_target) begin
            st_copying = 1'b0;
            st_stopped = 1'b1;
          end
        end
        st_elem_copied = '0;
        st_phase = tfr_pkg::PH_LEN;
      end
      tfr_pkg::PH_LEN: begin
        st_left = b;
        if (b == 8'd0) close_element();
        else st_phase = tfr_pkg::PH_VALUE;
      end
      default: begin
        if (st_copying && !st_stopped && st_cap_left != 0) begin
          r.dv = 1'b1;
          r.ob = b;
          st_cap_left = st_cap_left - 1'b1;
          st_elem_copied = st_elem_copied + 1'b1;
        end
        st_left = st_left - 1'b1;
        if (st_left == 8'd0) close_element();
      end
    endcase
    if (last) begin
      r.done = 1'b1;
      r.clen = st_committed;
      r.perr = (st_phase != tfr_pkg::PH_TYPE);
      clear_buffer_state();
    end
    return r.dv || last;
  endfunction

  function automatic void flag_error(input string msg);
    if (errors < 10) $display("%s", msg);
    errors++;
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int unsigned in_gap();
    if (in_mode == 0) return 0;
    if ($urandom_range(99) < (in_mode == 1 ? 20 : 50)) return idle_len();
    return 0;
  endfunction

  // Mostly well-formed buffers built around the current target type; some
  // are cut short and a few are plain noise.
  function automatic void build_buffer();
    int unsigned n_el;
    int unsigned len;
    int unsigned cut;
    int unsigned r;
    logic [7:0] elem_type;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 12)) buf_bytes.push_back(8'($urandom));
      return;
    end
    n_el = $urandom_range(1, 5);
    repeat (n_el) begin
      elem_type = ($urandom_range(99) < 65) ? reg_target : 8'($urandom);
      r = $urandom_range(99);
      if (r < 8) len = 0;
      else if (r < 90) len = $urandom_range(1, 8);
      else if (r < 97) len = $urandom_range(9, 40);
      else len = $urandom_range(128, 255);
      buf_bytes.push_back(elem_type);
      buf_bytes.push_back(8'(len));
      repeat (len) buf_bytes.push_back(8'($urandom));
    end
    if ($urandom_range(99) < 15 && buf_bytes.size() > 1) begin
      cut = $urandom_range(1, buf_bytes.size() - 1);
      while (buf_bytes.size() > cut) void'(buf_bytes.pop_back());
    end
  endfunction

  task automatic transfer_byte(input logic [7:0] b, input logic last, input bit typed,
                               input reasm_result_t want);
    int unsigned gap;
    reasm_result_t r;
    gap = in_gap();
    if (gap != 0) begin
      in_s.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_s.valid          <= 1'b1;
    in_s.data_byte      <= b;
    in_s.last_in_buffer <= last;
    @(posedge clk);
    while (!in_s.ready) @(posedge clk);
    if (predict_fragment(b, last, r)) pending_results.push_back(typed ? want : r);
    else if (typed) pending_results.push_back(want);
  endtask

  // Drain all results, then give element-end commands time to leave the queue.
  task automatic settle();
    in_s.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input logic [15:0] tgt_word, input logic [15:0] cap_word);
    cfg_we    <= 1'b1;
    cfg_index <= tfr_pkg::REG_TARGET_TYPE;
    cfg_data  <= tgt_word;
    @(posedge clk);
    reg_target = tgt_word[tfr_pkg::BYTE_W-1:0];
    cfg_index <= tfr_pkg::REG_CAPACITY;
    cfg_data  <= cap_word;
    @(posedge clk);
    reg_capacity = cap_word;
    if (!st_copying && !st_stopped) st_cap_left = reg_capacity;
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : result_monitor
    reasm_result_t got;
    reasm_result_t want;
    if (!rst && out_s.valid && out_s.ready) begin
      got = '{out_s.data_valid, out_s.out_byte, out_s.done_res, out_s.copied_length,
              out_s.parse_error};
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result: dv=%0b byte=%02h done=%0b len=%0d perr=%0b",
                             got.dv, got.ob, got.done, got.clen, got.perr));
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          flag_error($sformatf({"mismatch: expected dv=%0b byte=%02h done=%0b len=%0d ",
                                "perr=%0b, got dv=%0b byte=%02h done=%0b len=%0d perr=%0b"},
                               want.dv, want.ob, want.done, want.clen, want.perr,
                               got.dv, got.ob, got.done, got.clen, got.perr));
      end
    end
    if (out_hold != 0) begin
      out_hold--;
      out_s.ready <= 1'b0;
    end else if (out_mode != 0 && $urandom_range(99) < (out_mode == 1 ? 10 : 35)) begin
      out_hold = idle_len() - 1;
      out_s.ready <= 1'b0;
    end else begin
      out_s.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** tlv8_fragment_reassembler: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned random_sent;
    int unsigned quota;
    logic [15:0] tgt_word;
    logic [15:0] cap_word;
    logic [7:0]  b;
    logic        last;

    rst                 <= 1'b1;
    in_s.valid          <= 1'b0;
    in_s.data_byte      <= '0;
    in_s.last_in_buffer <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= tfr_pkg::REG_TARGET_TYPE;
    cfg_data            <= '0;
    reg_target   = tfr_pkg::TARGET_RESET;
    reg_capacity = tfr_pkg::CAPACITY_RESET;
    clear_buffer_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_settings(directed_rows[i].v0, directed_rows[i].v1);
      end else begin
        transfer_byte(directed_rows[i].v0[7:0], directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);
      end
    end
    settle();

    // Phases end at arbitrary bytes, so some settings change mid-buffer.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      in_mode  = $urandom_range(2);
      out_mode = $urandom_range(2);
      tgt_word = 16'($urandom);
      case ($urandom_range(2))
        0: tgt_word[7:0] = 8'h00;
        1: tgt_word[7:0] = 8'hFF;
        default: ;
      endcase
      case ($urandom_range(4))
        0: cap_word = 16'h0000;
        1: cap_word = 16'h0001;
        2: cap_word = 16'($urandom_range(2, 20));
        3: cap_word = 16'hFFFF;
        default: cap_word = 16'($urandom);
      endcase
      write_settings(tgt_word, cap_word);
      quota = $urandom_range(60, 200);
      if (quota > RANDOM_ITEMS - random_sent) quota = RANDOM_ITEMS - random_sent;
      repeat (quota) begin
        if (buf_bytes.size() == 0) build_buffer();
        b = buf_bytes.pop_front();
        last = (buf_bytes.size() == 0);
        transfer_byte(b, last, 1'b0, NO_RESULT);
        random_sent++;
      end
      settle();
    end

    if (errors == 0) begin
      $display("** tlv8_fragment_reassembler: PASSED **");
    end else begin
      $display("** tlv8_fragment_reassembler: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/tfr_pkg.sv
sv/tfr_if.sv
sv/tfr_front.sv
sv/tfr_queue.sv
sv/tfr_back.sv
sv/tlv8_fragment_reassembler.sv
tb/tlv8_fragment_reassembler_tb.sv
